// ----- hw/rtl/bpr_pkg.sv -----
// Shared types, constants and helpers for the byte pattern replacer.
`default_nettype none

package bpr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int IDX_W           = $clog2(MAX_PATTERN);
    localparam int CNT_W           = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH_DEF = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH    = 3'd0,
        CFG_PATTERN_BYTES     = 3'd1,
        CFG_REPLACEMENT_BYTES = 3'd2,
        CFG_WINDOW_START      = 3'd3,
        CFG_WINDOW_LENGTH     = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      pattern_bytes;
        logic [63:0]      replacement_bytes;
        logic [31:0]      window_start;
        logic [31:0]      window_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        from_replacement;
        logic        match_begin;
        logic [31:0] match_total;
        logic        run_last;
        logic        stream_done;
    } t_out_item;

    // One result byte of a request, with the number of matches begun up to it.
    typedef struct packed {
        logic [7:0]       value;
        logic             from_replacement;
        logic             match_begin;
        logic [CNT_W-1:0] match_idx;
    } t_slot;

    // All results caused by one request.
    typedef struct packed {
        t_slot [MAX_PATTERN-1:0] slot;
        logic [CNT_W-1:0]        count;
        logic [31:0]             base_total;
        logic                    end_of_stream;
    } t_bundle;

    function automatic logic [31:0] sat_add(input logic [31:0] base,
                                            input logic [CNT_W-1:0] inc);
        logic [32:0] sum;
        sum = {1'b0, base} + 33'(inc);
        return sum[32] ? '1 : sum[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bpr_stream_if.sv -----
// Valid/ready stream channel carrying one payload per request.
`default_nettype none

interface bpr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpr_front.sv -----
// Front end: holds pending bytes, matches the pattern and builds result bundles.
`default_nettype none

module bpr_front
    import bpr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_queue_full,
    output logic     o_push,
    output t_bundle  o_bundle
);

    logic [7:0]       r_pend [MAX_PATTERN];
    logic [7:0]       n_pend [MAX_PATTERN];
    logic [IDX_W-1:0] r_pend_cnt, n_pend_cnt;
    logic [31:0]      r_pos, n_pos;
    logic [31:0]      r_matches, n_matches;

    logic             accept;
    logic             eos;
    logic [LEN_W-1:0] len_clamp;
    logic [CNT_W-1:0] pat_len;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] scope;
    logic [7:0]       cand [MAX_PATTERN];
    logic [32:0]      win_end;
    logic [32:0]      start_pos [MAX_PATTERN];
    logic             open_ended;
    logic             in_win;
    logic             flush;
    logic             eq [MAX_PATTERN][MAX_PATTERN];
    logic [CNT_W-1:0] avail [MAX_PATTERN];
    logic             prefix_ok [MAX_PATTERN];
    logic             fits [MAX_PATTERN];
    logic             full_hit [MAX_PATTERN];
    logic             part_hit [MAX_PATTERN];

    logic [CNT_W-1:0] rem;
    logic [IDX_W-1:0] rep_off;
    logic             stopped;
    logic [CNT_W-1:0] hold_at;
    logic [CNT_W-1:0] n_match;
    logic [CNT_W:0]   src;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign eos        = i_in_item.end_of_stream;

    always_comb begin
        len_clamp = i_cfg.pattern_length;
        if (len_clamp == '0) begin
            len_clamp = LEN_W'(1);
        end else if (len_clamp > LEN_W'(MAX_PATTERN)) begin
            len_clamp = LEN_W'(MAX_PATTERN);
        end
        pat_len = CNT_W'(len_clamp);
    end

    assign open_ended = &i_cfg.window_length;
    assign win_end    = {1'b0, i_cfg.window_start} + {1'b0, i_cfg.window_length};
    assign in_win     = (r_pos >= i_cfg.window_start) &&
                        (open_ended || ({1'b0, r_pos} < win_end));
    assign flush      = eos || !in_win;
    assign fill       = CNT_W'(r_pend_cnt) + CNT_W'(1);
    // Outside the window the new byte only passes through and takes no part in matching.
    assign scope      = in_win ? fill : CNT_W'(r_pend_cnt);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (CNT_W'(k) == CNT_W'(r_pend_cnt)) begin
                cand[k] = i_in_item.in_byte;
            end else if (CNT_W'(k) < CNT_W'(r_pend_cnt)) begin
                cand[k] = r_pend[k];
            end else begin
                cand[k] = 8'h00;
            end
        end
    end

    // Check every start offset in parallel.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            start_pos[j] = {1'b0, r_pos} - 33'(r_pend_cnt) + 33'(j);
            fits[j]      = !start_pos[j][32] &&
                           (start_pos[j][31:0] >= i_cfg.window_start) &&
                           (open_ended || (start_pos[j] + 33'(pat_len) <= win_end));
            avail[j]     = scope - CNT_W'(j);
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (j + i < MAX_PATTERN) begin
                    eq[j][i] = (cand[j + i] == i_cfg.pattern_bytes[8 * i +: 8]);
                end else begin
                    eq[j][i] = 1'b0;
                end
            end
            prefix_ok[j] = 1'b1;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if ((CNT_W'(i) < avail[j]) && (CNT_W'(i) < pat_len) && !eq[j][i]) begin
                    prefix_ok[j] = 1'b0;
                end
            end
            full_hit[j] = fits[j] && prefix_ok[j] && (avail[j] >= pat_len);
            part_hit[j] = fits[j] && prefix_ok[j] && (avail[j] < pat_len);
        end
    end

    // Leftmost greedy scan: replace a full match, hold a live partial match, pass the rest.
    always_comb begin
        rem     = '0;
        rep_off = '0;
        stopped = 1'b0;
        hold_at = fill;
        n_match = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            o_bundle.slot[i].value            = cand[i];
            o_bundle.slot[i].from_replacement = 1'b0;
            o_bundle.slot[i].match_begin      = 1'b0;
            if ((CNT_W'(i) < scope) && !stopped) begin
                if (rem != '0) begin
                    o_bundle.slot[i].value =
                        i_cfg.replacement_bytes[{rep_off, 3'b000} +: 8];
                    o_bundle.slot[i].from_replacement = 1'b1;
                    rep_off = rep_off + IDX_W'(1);
                    rem     = rem - CNT_W'(1);
                end else if (full_hit[i]) begin
                    o_bundle.slot[i].value            = i_cfg.replacement_bytes[7:0];
                    o_bundle.slot[i].from_replacement = 1'b1;
                    o_bundle.slot[i].match_begin      = 1'b1;
                    n_match = n_match + CNT_W'(1);
                    rep_off = IDX_W'(1);
                    rem     = pat_len - CNT_W'(1);
                end else if (!flush && part_hit[i]) begin
                    stopped = 1'b1;
                    hold_at = CNT_W'(i);
                end
            end
            o_bundle.slot[i].match_idx = n_match;
        end
        o_bundle.count         = hold_at;
        o_bundle.base_total    = r_matches;
        o_bundle.end_of_stream = eos;
    end

    assign o_push = accept && (hold_at != '0);

    always_comb begin
        src = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            src = {1'b0, hold_at} + (CNT_W + 1)'(k);
            if (src < (CNT_W + 1)'(MAX_PATTERN)) begin
                n_pend[k] = cand[src[IDX_W-1:0]];
            end else begin
                n_pend[k] = 8'h00;
            end
        end
        n_pend_cnt = stopped ? IDX_W'(fill - hold_at) : '0;
        n_pos      = eos ? '0 : r_pos + 32'd1;
        n_matches  = eos ? '0 : sat_add(r_matches, n_match);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
            r_pos      <= '0;
            r_matches  <= '0;
        end else if (accept) begin
            r_pend_cnt <= n_pend_cnt;
            r_pos      <= n_pos;
            r_matches  <= n_matches;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && eos |=> (r_pend_cnt == '0) && (r_pos == '0) && (r_matches == '0))
        else $error("stream state not cleared after end of stream");

    a_eos_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && eos |-> o_push && (o_bundle.count != '0))
        else $error("end of stream request produced no results");

endmodule

`default_nettype wire

// ----- hw/rtl/bpr_queue.sv -----
// Bundle queue between front and back end.
`default_nettype none

module bpr_queue
    import bpr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_data
);

    // DEPTH ranges from 2 upward.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle       r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("bundle queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("bundle queue underflow");

endmodule

`default_nettype wire

// ----- hw/rtl/bpr_back.sv -----
// Back end: walks bundles; one result per cycle via an output register unless stalled.
`default_nettype none

module bpr_back
    import bpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_bundle   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_out_item        r_item;
    t_out_item        n_item;
    t_slot            cur;
    logic             last;
    logic             load;

    assign cur   = i_head.slot[r_idx];
    assign last  = (CNT_W'(r_idx) + CNT_W'(1)) == i_head.count;
    // Refill the output register when it is empty or being taken.
    assign load  = i_head_valid && (!r_valid || i_out_ready);
    assign o_pop = load && last;

    always_comb begin
        n_item.out_byte         = cur.value;
        n_item.from_replacement = cur.from_replacement;
        n_item.match_begin      = cur.match_begin;
        n_item.match_total      = sat_add(i_head.base_total, cur.match_idx);
        n_item.run_last         = last;
        n_item.stream_done      = last && i_head.end_of_stream;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= last ? '0 : r_idx + IDX_W'(1);
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.stream_done |-> r_item.run_last)
        else $error("stream end flagged on a result that is not the last of its request");

endmodule

`default_nettype wire

// ----- hw/rtl/byte_pattern_replace.sv -----
// Streaming find-and-replace of a configured byte pattern inside a position window.
//
// Input channel i_in_chan carries one byte and an end-of-stream flag per request;
// output channel o_out_chan carries one result byte with its flags and the running
// match count. Both use valid/ready; a request moves when both are high.
// The configuration port writes register i_cfg_index from i_cfg_data whenever
// i_cfg_we is high; write it only while no results are outstanding.
// Throughput: one request per cycle while the queue has room, one result per cycle
// while the receiver is ready. Up to seven bytes may be held back while they can
// still begin a match, so a request can produce no result and a later one up to
// eight. The match search over all start offsets is combinational in the front end.
// With the bundle queue empty, the front end registers a request's first result into
// the queue, and the queue head then loads it into the output register.
// When the receiver stalls, the output register holds its result, the queue of
// QUEUE_DEPTH bundles absorbs further requests, and input ready drops once it is full.
// Reset clears the configuration to its defaults, the held bytes, the stream position
// and the match count; no clearing pass is needed.
`default_nettype none

module byte_pattern_replace
    import bpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpr_stream_if.sink            i_in_chan,
    bpr_stream_if.source          o_out_chan,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      front_ready;
    logic      push;
    t_bundle   push_bundle;
    logic      queue_full;
    logic      head_valid;
    t_bundle   head_bundle;
    logic      pop;
    logic      out_valid;
    t_out_item out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length    <= LEN_W'(1);
            r_cfg.pattern_bytes     <= '0;
            r_cfg.replacement_bytes <= '0;
            r_cfg.window_start      <= '0;
            r_cfg.window_length     <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LENGTH:    r_cfg.pattern_length    <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_BYTES:     r_cfg.pattern_bytes     <= i_cfg_data[63:0];
                CFG_REPLACEMENT_BYTES: r_cfg.replacement_bytes <= i_cfg_data[63:0];
                CFG_WINDOW_START:      r_cfg.window_start      <= i_cfg_data[31:0];
                CFG_WINDOW_LENGTH:     r_cfg.window_length     <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    bpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_chan.valid),
        .o_in_ready   (front_ready),
        .i_in_item    (i_in_chan.payload),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    assign i_in_chan.ready = front_ready;

    bpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_bundle)
    );

    bpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_bundle),
        .o_pop        (pop),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out_chan.ready),
        .o_out_item   (out_item)
    );

    assign o_out_chan.valid   = out_valid;
    assign o_out_chan.payload = out_item;

endmodule

`default_nettype wire

// ----- sim/byte_pattern_replace_test.sv -----
// Self-checking testbench for byte_pattern_replace: random and directed streams.
module byte_pattern_replace_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpr_pkg::*;

    localparam int          CLK_PERIOD   = 20;
    localparam int unsigned LIMIT_NS     = 20_000_000;
    localparam int unsigned RANDOM_ITEMS = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  feed_valid = 1'b0;
    t_in_item              feed_item  = '0;
    logic                  sink_ready = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    bpr_stream_if #(.t_payload(t_in_item))  in_chan();
    bpr_stream_if #(.t_payload(t_out_item)) out_chan();

    assign in_chan.valid   = feed_valid;
    assign in_chan.payload = feed_item;
    assign out_chan.ready  = sink_ready;

    byte_pattern_replace u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_chan   (in_chan),
        .o_out_chan  (out_chan),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Replacer settings as last written.
    logic [3:0]  pat_len_reg   = 4'd1;
    logic [63:0] pat_reg       = '0;
    logic [63:0] rep_reg       = '0;
    logic [31:0] win_start_reg = '0;
    logic [31:0] win_len_reg   = '1;

    // Replacer state.
    logic [7:0]  held_bytes [MAX_PATTERN] = '{default: 8'h00};
    int unsigned held_count   = 0;
    logic [31:0] stream_pos   = '0;
    logic [31:0] match_count  = '0;

    t_out_item   step_bytes[$];
    t_out_item   expected_bytes[$];
    t_in_item    byte_feed[$];

    int unsigned items_queued   = 0;
    int unsigned items_taken    = 0;
    int          mismatch_count = 0;
    int          feed_wait      = 0;
    int          sink_wait      = 0;
    bit          feed_calm      = 1'b0;
    bit          sink_calm      = 1'b0;

    function automatic int unsigned active_len();
        if (pat_len_reg == 4'd0) return 1;
        if (pat_len_reg > MAX_PATTERN) return MAX_PATTERN;
        return 32'(pat_len_reg);
    endfunction

    function automatic bit held_prefix_matches(int unsigned k);
        for (int i = 0; i < k; i++)
            if (held_bytes[i] != pat_reg[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void drop_held(int unsigned k);
        if (k >= held_count) begin
            held_count = 0;
        end else begin
            for (int i = 0; i < held_count - k; i++) held_bytes[i] = held_bytes[i + k];
            held_count = held_count - k;
        end
    endfunction

    function automatic void queue_result(logic [7:0] b, bit from_rep, bit first);
        t_out_item r;
        r                  = '0;
        r.out_byte         = b;
        r.from_replacement = from_rep;
        r.match_begin      = first;
        r.match_total      = match_count;
        step_bytes.push_back(r);
    endfunction

    // Release held bytes until the front one could still start a match.
    task automatic settle_held(logic [32:0] next, bit flush);
        int unsigned plen;
        logic [33:0] s;
        bit          fits;
        while (held_count > 0) begin
            plen = active_len();
            fits = 1'b0;
            if (next >= held_count) begin
                s    = 34'(next) - 34'(held_count);
                fits = (s >= win_start_reg) &&
                       (win_len_reg == '1 || s + plen <= {2'b00, win_start_reg} + win_len_reg);
            end
            if (fits && held_count >= plen && held_prefix_matches(plen)) begin
                if (match_count != '1) match_count++;
                for (int i = 0; i < plen; i++) queue_result(rep_reg[8*i +: 8], 1'b1, i == 0);
                drop_held(plen);
            end else if (!flush && fits && held_count < plen &&
                         held_prefix_matches(held_count)) begin
                break;
            end else begin
                queue_result(held_bytes[0], 1'b0, 1'b0);
                drop_held(1);
            end
        end
    endtask

    task automatic replace_byte(t_in_item it);
        logic [32:0] pos;
        bit          in_window;
        t_out_item   tail;
        step_bytes.delete();
        pos       = {1'b0, stream_pos};
        in_window = (stream_pos >= win_start_reg) &&
                    (win_len_reg == '1 || pos < {1'b0, win_start_reg} + win_len_reg);
        if (in_window && held_count < MAX_PATTERN) begin
            held_bytes[held_count] = it.in_byte;
            held_count++;
            settle_held(pos + 1, it.end_of_stream);
        end else begin
            settle_held(pos, 1'b1);
            queue_result(it.in_byte, 1'b0, 1'b0);
        end
        if (step_bytes.size() > 0) begin
            tail             = step_bytes.pop_back();
            tail.run_last    = 1'b1;
            tail.stream_done = it.end_of_stream;
            step_bytes.push_back(tail);
        end
        foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
        if (it.end_of_stream) begin
            stream_pos  = '0;
            match_count = '0;
            held_count  = 0;
        end else begin
            stream_pos = stream_pos + 1;
        end
    endtask

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            feed_valid <= 1'b0;
            feed_wait  <= 0;
        end else begin
            if (feed_valid && in_chan.ready) begin
                replace_byte(feed_item);
                items_taken++;
            end
            if (!feed_valid || in_chan.ready) begin
                if (feed_wait > 0) begin
                    feed_valid <= 1'b0;
                    feed_wait  <= feed_wait - 1;
                end else if (byte_feed.size() > 0) begin
                    feed_valid <= 1'b1;
                    feed_item  <= byte_feed.pop_front();
                    feed_wait  <= pick_gap(feed_calm);
                end else begin
                    feed_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            sink_wait  <= 0;
        end else begin
            if (sink_ready && out_chan.valid) begin
                got = out_chan.payload;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result byte %0h", got.out_byte);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
                    check_field("from_replacement", 32'(want.from_replacement),
                                32'(got.from_replacement));
                    check_field("match_begin", 32'(want.match_begin), 32'(got.match_begin));
                    check_field("match_total", want.match_total, got.match_total);
                    check_field("run_last", 32'(want.run_last), 32'(got.run_last));
                    check_field("stream_done", 32'(want.stream_done), 32'(got.stream_done));
                end
            end
            if (sink_wait > 0) begin
                sink_ready <= 1'b0;
                sink_wait  <= sink_wait - 1;
            end else if (!sink_calm && $urandom_range(0, 99) < 15) begin
                sink_ready <= 1'b0;
                sink_wait  <= pick_gap(1'b0);
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    function automatic void push_byte(logic [7:0] b, bit eos);
        t_in_item it;
        it.in_byte       = b;
        it.end_of_stream = eos;
        byte_feed.push_back(it);
        items_queued++;
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [63:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PATTERN_LENGTH:    pat_len_reg   = data[3:0];
            CFG_PATTERN_BYTES:     pat_reg       = data;
            CFG_REPLACEMENT_BYTES: rep_reg       = data;
            CFG_WINDOW_START:      win_start_reg = data[31:0];
            CFG_WINDOW_LENGTH:     win_len_reg   = data[31:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [63:0] len, logic [63:0] pat, logic [63:0] rep,
                                  logic [63:0] ws, logic [63:0] wl);
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        write_reg(CFG_WINDOW_START, ws);
        write_reg(CFG_WINDOW_LENGTH, wl);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every request is taken and answered, then let the pipe settle.
    task automatic drain();
        while (items_taken != items_queued) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic random_phase(int idx);
        logic [7:0]  alphabet [4];
        logic [63:0] len_word;
        logic [63:0] pat;
        logic [31:0] ws;
        logic [31:0] wl;
        int unsigned plen;
        int unsigned span;
        int unsigned start;
        int unsigned k;
        for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len_word[3:0] = 4'd0;
            1:       len_word[3:0] = 4'($urandom_range(9, 15));
            default: len_word[3:0] = 4'($urandom_range(1, 8));
        endcase
        if (idx == 0) len_word[3:0] = 4'd0;
        if (idx == 1) len_word[3:0] = 4'd15;
        for (int i = 0; i < 8; i++) pat[8*i +: 8] = alphabet[$urandom_range(0, 3)];
        case ($urandom_range(0, 7))
            0, 1, 2: ws = '0;
            3, 4:    ws = $urandom_range(1, 20);
            5:       ws = '1;
            6:       ws = $urandom;
            default: ws = $urandom_range(0, 5);
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: wl = '1;
            3:       wl = '0;
            4, 5:    wl = $urandom_range(1, 40);
            6:       wl = 32'hFFFF_FFFE;
            default: wl = 32'h8000_0000;
        endcase
        // Window end past the top of the position range.
        if (idx == 2) begin
            ws = 32'd7;
            wl = 32'hFFFF_FFFE;
        end
        if (idx == 3) wl = '0;
        apply_settings(len_word, pat, {$urandom, $urandom}, {$urandom, ws}, {$urandom, wl});

        plen  = active_len();
        span  = $urandom_range(30, 60);
        start = items_queued;
        while (items_queued - start < span) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    for (int i = 0; i < plen; i++)
                        push_byte(pat[8*i +: 8], $urandom_range(0, 39) == 0);
                end
                5, 6: begin
                    k = $urandom_range(1, plen);
                    for (int i = 0; i < k; i++)
                        push_byte(pat[8*i +: 8], $urandom_range(0, 39) == 0);
                    push_byte(alphabet[$urandom_range(0, 3)], $urandom_range(0, 39) == 0);
                end
                7, 8:    push_byte(alphabet[$urandom_range(0, 3)], $urandom_range(0, 39) == 0);
                default: push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
            endcase
        end
        // Leave the stream open now and then so the next settings judge held bytes.
        if ($urandom_range(0, 9) < 7) push_byte(alphabet[$urandom_range(0, 3)], 1'b1);
    endtask

    initial begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int unsigned directed_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: single zero byte pattern.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        // Failed partial match restarts one byte later; partial match flushed at end.
        apply_settings(64'd3, 64'h43_42_41, 64'h7A_79_78, 64'd0, 64'hFFFF_FFFF);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        drain();

        // Longest pattern: one request releases eight replacement bytes.
        apply_settings(64'd8, '1, 64'h0807_0605_0403_0201, 64'd0, 64'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        // Match cut by the window end passes through unchanged.
        apply_settings(64'd2, 64'h42_41, 64'h5A_59, 64'd2, 64'd3);
        for (int i = 0; i < 3; i++) begin
            push_byte(8'h41, 1'b0);
            push_byte(8'h42, i == 2);
        end
        drain();

        directed_items = items_queued;
        phase = 0;
        while (items_queued < directed_items + RANDOM_ITEMS) begin
            feed_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            random_phase(phase);
            drain();
            phase++;
        end

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bpr_pkg.sv
hw/rtl/bpr_stream_if.sv
hw/rtl/bpr_front.sv
hw/rtl/bpr_queue.sv
hw/rtl/bpr_back.sv
hw/rtl/byte_pattern_replace.sv
sim/byte_pattern_replace_test.sv
